// ----- hw/rtl/obdp_pkg.sv -----
// ----------------------------------------------------------------------------
// obdp_pkg
// Shared codes, constants and beat layouts for the OBD request/response poller.
// ----------------------------------------------------------------------------
package obdp_pkg;

	// input selector codes (s_tuser)
	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_FRAME = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;
	localparam logic [1:0] FUNC_STATS = 2'd3;

	// result kind codes (m_tuser)
	localparam logic [2:0] KIND_REQ     = 3'd0;
	localparam logic [2:0] KIND_OK      = 3'd1;
	localparam logic [2:0] KIND_TIMEOUT = 3'd2;
	localparam logic [2:0] KIND_TXFAIL  = 3'd3;
	localparam logic [2:0] KIND_STATS   = 3'd4;

	// configuration register indexes (paddr[3:2])
	localparam logic [1:0] REG_REQUEST_ID  = 2'd0;
	localparam logic [1:0] REG_RESPONSE_ID = 2'd1;
	localparam logic [1:0] REG_TIMEOUT_US  = 2'd2;

	localparam logic [10:0] REQUEST_ID_RST  = 11'h7E0;
	localparam logic [10:0] RESPONSE_ID_RST = 11'h7E8;
	localparam logic [15:0] TIMEOUT_US_RST  = 16'd30000;

	localparam logic [7:0] PAD_BYTE        = 8'h55;
	localparam logic [7:0] POSITIVE_OFFSET = 8'h40;
	localparam logic [7:0] PCI_TYPE_MASK   = 8'hF0;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 288;

	// input beat, highest bit first
	typedef struct packed {
		logic [3:0]  pad;
		logic        tx_accepted;
		logic [7:0]  byte3;
		logic [7:0]  byte2;
		logic [7:0]  byte1;
		logic [7:0]  byte0;
		logic [3:0]  length;
		logic        frame_remote;
		logic        frame_extended;
		logic [28:0] rx_can_id;
	} in_beat_t;

	// result beat, highest bit first
	typedef struct packed {
		logic [31:0] cum_txfail;
		logic [31:0] cum_timeout;
		logic [31:0] cum_ok;
		logic [15:0] rtt_max_us;
		logic [15:0] rtt_min_us;
		logic [31:0] rtt_sum_us;
		logic [15:0] win_txerr;
		logic [15:0] win_tmo;
		logic [15:0] win_ok;
		logic [15:0] rtt_us;
		logic [63:0] tx_payload;
	} out_beat_t;

endpackage

// ----- hw/rtl/obd_request_response_poller.sv -----
// ----------------------------------------------------------------------------
// obd_request_response_poller
// Builds single-frame diagnostic requests, times the matching response and
// keeps window and cumulative round-trip statistics.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; a result beat is computed
// from the beat held in the input register and presented from the result register.
// Throughput: one input beat per cycle; a stalled result register holds the
// input stage only when the waiting item itself has a result to deliver.
// Reset: arst_n clears the poll state, all counters and the configuration
// registers to their defaults at once; no clearing pass.
module obd_request_response_poller (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// rx_can_id[28:0], frame_extended, frame_remote, length[3:0], byte0, byte1,
	// byte2, byte3, tx_accepted, zero fill
	input  logic [obdp_pkg::IN_DATA_W-1:0]  s_tdata,
	// func[1:0]
	input  logic [1:0]                      s_tuser,
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// tx_payload[63:0], rtt_us, win_ok, win_tmo, win_txerr, rtt_sum_us[31:0],
	// rtt_min_us, rtt_max_us, cum_ok[31:0], cum_timeout[31:0], cum_txfail[31:0]
	output logic [obdp_pkg::OUT_DATA_W-1:0] m_tdata,
	// kind[2:0]
	output logic [2:0]                      m_tuser,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [3:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import obdp_pkg::*;

	// configuration
	logic [10:0] request_id_q;
	logic [10:0] response_id_q;
	logic [15:0] timeout_us_q;
	logic        cfg_wr;

	// input stage
	logic        valid_s1;
	logic [1:0]  func_s1;
	in_beat_t    data_s1;

	// result stage
	logic        valid_s2;
	logic [2:0]  kind_s2;
	out_beat_t   data_s2;

	// poll state
	logic        waiting_q;
	logic [7:0]  req_bytes_q [3];
	logic [1:0]  req_len_q;
	logic [15:0] elapsed_q;
	logic [15:0] win_ok_q, win_tmo_q, win_txerr_q;
	logic [31:0] rtt_sum_q;
	logic [15:0] rtt_min_q, rtt_max_q;
	logic [31:0] cum_ok_q, cum_timeout_q, cum_txfail_q;

	// next state
	logic        waiting_d;
	logic        req_load;
	logic [1:0]  req_len_d;
	logic [15:0] elapsed_d;
	logic [15:0] win_ok_d, win_tmo_d, win_txerr_d;
	logic [31:0] rtt_sum_d;
	logic [15:0] rtt_min_d, rtt_max_d;
	logic [31:0] cum_ok_d, cum_timeout_d, cum_txfail_d;

	logic        res_valid;
	logic [2:0]  res_kind;
	out_beat_t   res_data;
	logic        out_free;
	logic        step;

	logic [1:0]  start_len;
	logic [63:0] start_payload;
	logic        frame_match;
	logic [15:0] elapsed_inc;
	logic [32:0] sum_wide;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_id_q  <= REQUEST_ID_RST;
			response_id_q <= RESPONSE_ID_RST;
			timeout_us_q  <= TIMEOUT_US_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_REQUEST_ID:  request_id_q  <= pwdata[10:0];
				REG_RESPONSE_ID: response_id_q <= pwdata[10:0];
				REG_TIMEOUT_US:  timeout_us_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_REQUEST_ID:  prdata = {21'd0, request_id_q};
			REG_RESPONSE_ID: prdata = {21'd0, response_id_q};
			REG_TIMEOUT_US:  prdata = {16'd0, timeout_us_q};
			default:         prdata = '0;
		endcase
	end

	// ---------------- handshake ----------------
	assign out_free = !valid_s2 || m_tready;
	assign step     = valid_s1 && (!res_valid || out_free);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser;
			data_s1 <= in_beat_t'(s_tdata);
		end
	end

	// ---------------- item logic ----------------
	assign start_len = (data_s1.length > 4'd3) ? 2'd3 : data_s1.length[1:0];
	assign start_payload = {6'd0, start_len, data_s1.byte0,
		(start_len >= 2'd2) ? data_s1.byte1 : PAD_BYTE,
		(start_len == 2'd3) ? data_s1.byte2 : PAD_BYTE,
		PAD_BYTE, PAD_BYTE, PAD_BYTE, PAD_BYTE};

	assign frame_match = (data_s1.rx_can_id == {18'd0, response_id_q})
		&& !data_s1.frame_extended && !data_s1.frame_remote
		&& (data_s1.length >= 4'd3)
		&& ((data_s1.byte0 & PCI_TYPE_MASK) == 8'd0)
		&& (data_s1.byte1 == 8'(req_bytes_q[0] + POSITIVE_OFFSET))
		&& (req_len_q < 2'd2 || data_s1.byte2 == req_bytes_q[1])
		&& (req_len_q < 2'd3 || data_s1.byte3 == req_bytes_q[2]);

	assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
	assign sum_wide    = {1'b0, rtt_sum_q} + {17'd0, elapsed_q};

	always_comb begin
		res_valid     = 1'b0;
		res_kind      = KIND_REQ;
		res_data      = '0;
		waiting_d     = waiting_q;
		req_load      = 1'b0;
		req_len_d     = req_len_q;
		elapsed_d     = elapsed_q;
		win_ok_d      = win_ok_q;
		win_tmo_d     = win_tmo_q;
		win_txerr_d   = win_txerr_q;
		rtt_sum_d     = rtt_sum_q;
		rtt_min_d     = rtt_min_q;
		rtt_max_d     = rtt_max_q;
		cum_ok_d      = cum_ok_q;
		cum_timeout_d = cum_timeout_q;
		cum_txfail_d  = cum_txfail_q;
		case (func_s1)
			FUNC_START: begin
				if (!waiting_q && data_s1.length != 4'd0) begin
					res_valid           = 1'b1;
					res_data.tx_payload = start_payload;
					if (!data_s1.tx_accepted) begin
						res_kind    = KIND_TXFAIL;
						win_txerr_d = (win_txerr_q == 16'hFFFF) ? win_txerr_q
							: win_txerr_q + 16'd1;
						cum_txfail_d = (cum_txfail_q == 32'hFFFF_FFFF) ? cum_txfail_q
							: cum_txfail_q + 32'd1;
					end else begin
						res_kind  = KIND_REQ;
						req_load  = 1'b1;
						req_len_d = start_len;
						elapsed_d = '0;
						waiting_d = 1'b1;
					end
				end
			end
			FUNC_FRAME: begin
				if (waiting_q && frame_match) begin
					res_valid       = 1'b1;
					res_kind        = KIND_OK;
					res_data.rtt_us = elapsed_q;
					rtt_sum_d = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
					if (elapsed_q < rtt_min_q) rtt_min_d = elapsed_q;
					if (elapsed_q > rtt_max_q) rtt_max_d = elapsed_q;
					win_ok_d  = (win_ok_q == 16'hFFFF) ? win_ok_q : win_ok_q + 16'd1;
					cum_ok_d  = (cum_ok_q == 32'hFFFF_FFFF) ? cum_ok_q : cum_ok_q + 32'd1;
					waiting_d = 1'b0;
				end
			end
			FUNC_TICK: begin
				if (waiting_q) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= timeout_us_q) begin
						res_valid     = 1'b1;
						res_kind      = KIND_TIMEOUT;
						win_tmo_d     = (win_tmo_q == 16'hFFFF) ? win_tmo_q
							: win_tmo_q + 16'd1;
						cum_timeout_d = (cum_timeout_q == 32'hFFFF_FFFF) ? cum_timeout_q
							: cum_timeout_q + 32'd1;
						waiting_d     = 1'b0;
					end
				end
			end
			default: begin
				// stats read: report the window and cumulative counts, then clear the window
				res_valid            = 1'b1;
				res_kind             = KIND_STATS;
				res_data.win_ok      = win_ok_q;
				res_data.win_tmo     = win_tmo_q;
				res_data.win_txerr   = win_txerr_q;
				res_data.rtt_sum_us  = rtt_sum_q;
				res_data.rtt_min_us  = (win_ok_q != 16'd0) ? rtt_min_q : 16'd0;
				res_data.rtt_max_us  = rtt_max_q;
				res_data.cum_ok      = cum_ok_q;
				res_data.cum_timeout = cum_timeout_q;
				res_data.cum_txfail  = cum_txfail_q;
				win_ok_d      = '0;
				win_tmo_d     = '0;
				win_txerr_d   = '0;
				rtt_sum_d     = '0;
				rtt_min_d     = 16'hFFFF;
				rtt_max_d     = '0;
			end
		endcase
	end

	// ---------------- state update ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q      <= 1'b0;
			req_bytes_q[0] <= '0;
			req_bytes_q[1] <= '0;
			req_bytes_q[2] <= '0;
			req_len_q      <= '0;
			elapsed_q      <= '0;
			win_ok_q       <= '0;
			win_tmo_q      <= '0;
			win_txerr_q    <= '0;
			rtt_sum_q      <= '0;
			rtt_min_q      <= 16'hFFFF;
			rtt_max_q      <= '0;
			cum_ok_q       <= '0;
			cum_timeout_q  <= '0;
			cum_txfail_q   <= '0;
		end else if (step) begin
			waiting_q     <= waiting_d;
			req_len_q     <= req_len_d;
			elapsed_q     <= elapsed_d;
			win_ok_q      <= win_ok_d;
			win_tmo_q     <= win_tmo_d;
			win_txerr_q   <= win_txerr_d;
			rtt_sum_q     <= rtt_sum_d;
			rtt_min_q     <= rtt_min_d;
			rtt_max_q     <= rtt_max_d;
			cum_ok_q      <= cum_ok_d;
			cum_timeout_q <= cum_timeout_d;
			cum_txfail_q  <= cum_txfail_d;
			if (req_load) begin
				req_bytes_q[0] <= data_s1.byte0;
				req_bytes_q[1] <= data_s1.byte1;
				req_bytes_q[2] <= data_s1.byte2;
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step && res_valid) begin
			kind_s2 <= res_kind;
			data_s2 <= res_data;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = kind_s2;
	assign m_tdata  = data_s2;

`ifndef SYNTHESIS
	// an empty input stage always takes a beat
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stage empty but not ready");

	// a sent request opens the wait
	a_req_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_valid && res_kind == KIND_REQ) |=> waiting_q)
		else $error("request sent without entering wait");

	// a response or a timeout closes the wait
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_valid && (res_kind == KIND_OK || res_kind == KIND_TIMEOUT))
		|=> !waiting_q)
		else $error("wait not closed after response or timeout");

	// a result only leaves a stage that held an item
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(out_free && step && res_valid) |-> valid_s1)
		else $error("result produced without an item");
`endif

endmodule
